>>> hdl/deq_pkg.sv
// shared types and constants of the double-ended queue
package deq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int TOKEN_WIDTH_DEFAULT = 32;

    // request codes
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_CLEAR      = 3'd6
    } action_t;

    // answer codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

>>> hdl/deq_ram.sv
// single-port slot memory with registered read data
module deq_ram
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int WIDTH = TOKEN_WIDTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

>>> hdl/double_ended_queue.sv
// top level of the double-ended queue: request decode, pointers and result stages
//
// A deque of TOKEN_WIDTH-bit words kept in a circular buffer of DEPTH slots.
// Each request word on the s_ side carries an action (push front/back, pop
// front/back, peek front/back, clear) and a token; each request yields exactly
// one result word on the m_ side with a status (ok, empty, full), a has_token
// flag and the popped or peeked word (zero when has_token is low). A push onto
// a full deque is dropped and answered full; a pop or peek of an empty deque
// is answered empty; the unused action code changes nothing and answers ok.
// Clear only resets the pointers, slot contents stay. The slots live in one
// single-port synchronous memory, touched at most once per request (read for
// pop and peek, write for push), so the block takes one request per cycle
// while the result side keeps up; a result passes the stage register and then
// the result register. Since each request touches the memory in its own cycle
// and a read returns on the following edge, a push followed directly by a pop
// of the same slot sees the fresh word without any forwarding. No clearing
// pass after reset: slots are only read once a push has written them.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int TOKEN_WIDTH = TOKEN_WIDTH_DEFAULT,
    localparam int DW         = ((3 + TOKEN_WIDTH + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request side
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [DW-1:0] s_tdata,  // action[2:0], token, zero fill
    // result side
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [DW-1:0] m_tdata   // status[1:0], has_token, token_out, zero fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // request fields
    action_t                act;
    logic [TOKEN_WIDTH-1:0] tok;

    // pointer state
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    // stage between memory access and result register
    logic    p_valid_reg, p_valid_next;
    status_t p_status_reg, p_status_next;
    logic    p_has_reg, p_has_next;

    // result register
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg;
    logic                   m_has_reg;
    logic [TOKEN_WIDTH-1:0] m_token_reg;

    // memory port
    logic                   mem_en, mem_we;
    logic [AW-1:0]          mem_addr;
    logic [TOKEN_WIDTH-1:0] mem_rdata;

    logic advance, accept, is_full, is_empty;
    logic [AW:0]   back_sum, tail_sum;
    logic [AW-1:0] back_idx, tail_idx, front_dec, front_inc;

    assign act = action_t'(s_tdata[2:0]);
    assign tok = s_tdata[3 +: TOKEN_WIDTH];

    // the pipe moves whenever the result register is free or being taken
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // back token slot: front + count - 1, wrapped once
    assign back_sum = (AW+1)'(front_reg) + (AW+1)'(count_reg) - (AW+1)'(1);
    assign back_idx = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                   : AW'(back_sum);
    // first free slot behind the back: front + count, wrapped once
    assign tail_sum = (AW+1)'(front_reg) + (AW+1)'(count_reg);
    assign tail_idx = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : AW'(tail_sum);

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    // request decode
    always_comb begin
        front_next    = front_reg;
        count_next    = count_reg;
        p_status_next = ST_OK;
        p_has_next    = 1'b0;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = front_reg;
        unique case (act) inside
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (is_full) begin
                    p_status_next = ST_FULL;
                end else begin
                    mem_en     = accept;
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (act == ACT_PUSH_FRONT) begin
                        front_next = front_dec;
                        mem_addr   = front_dec;
                    end else begin
                        mem_addr   = tail_idx;
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                if (is_empty) begin
                    p_status_next = ST_EMPTY;
                end else begin
                    mem_en     = accept;
                    p_has_next = 1'b1;
                    if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) begin
                        mem_addr = front_reg;
                    end else begin
                        mem_addr = back_idx;
                    end
                    if (act == ACT_POP_FRONT) begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end else if (act == ACT_POP_BACK) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            ACT_CLEAR: begin
                front_next = '0;
                count_next = '0;
            end
            default: begin
                // unused code: no change, answers ok
            end
        endcase
    end

    // stage valid flags
    always_comb begin
        p_valid_next = p_valid_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            p_valid_next = accept;
            m_valid_next = p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            count_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_status_reg <= p_status_next;
            p_has_reg    <= p_has_next;
        end
        if (advance) begin
            // read data holds until the next accepted pop or peek of a non-empty deque
            m_status_reg <= p_status_reg;
            m_has_reg    <= p_has_reg;
            m_token_reg  <= p_has_reg ? mem_rdata : '0;
        end
    end

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (TOKEN_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (tok),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'({m_token_reg, m_has_reg, m_status_reg});

endmodule
